>>> rtl/core/tpal_pkg.sv
// Shared types and constants for the threshold promote address list.
package tpal_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned DEPTH_DEF   = 16;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned POS_OUT_W   = 4;
  localparam int unsigned OCC_OUT_W   = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } tpal_state_t;

  // per-cell update controls
  typedef struct packed {
    logic load_left;   // take neighbour's entry (shift towards the back)
    logic load_count;  // write new count in place
    logic clear;       // drop this entry (eviction)
  } tpal_cell_ctrl_t;

endpackage

>>> rtl/core/tpal_cell.sv
// One list cell: holds an entry, compares it and shifts from its neighbour.
module tpal_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  tpal_pkg::tpal_cell_ctrl_t      ctrl,
  input  logic [tpal_pkg::KEY_W-1:0]     left_key,
  input  logic [tpal_pkg::COUNT_W-1:0]   left_count,
  input  logic                           left_valid,
  input  logic [tpal_pkg::KEY_W-1:0]     cmp_key,
  input  logic [tpal_pkg::COUNT_W-1:0]   new_count,
  output logic [tpal_pkg::KEY_W-1:0]     ent_key,
  output logic [tpal_pkg::COUNT_W-1:0]   ent_count,
  output logic                           ent_valid,
  output logic                           match
);
  import tpal_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      ent_key   <= '0;
      ent_count <= '0;
    end else if (ctrl.clear) begin
      ent_valid <= 1'b0;
      ent_key   <= '0;
      ent_count <= '0;
    end else if (ctrl.load_left) begin
      ent_valid <= left_valid;
      ent_key   <= left_key;
      ent_count <= left_count;
    end else if (ctrl.load_count) begin
      ent_count <= new_count;
    end
  end

  assign match = ent_valid && (ent_key == cmp_key);

endmodule

>>> rtl/core/threshold_promote_address_list.sv
// Top level of the threshold promote address list.
// Usage:
//   Input channel (in_valid/in_ready, access_key) takes one key per transaction.
//   Output channel (out_valid/out_ready) returns one result per key: hit flag,
//   position before any move, new count, promotion, eviction and occupancy.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes capacity
//   (index 0) and promote limit (index 1); write only while the block is idle.
// Timing:
//   An accepted key is searched in the cycle after acceptance (every cell
//   compares in parallel); the list is then rewritten in the update state,
//   when the result is loaded into the output register. A new key is
//   accepted in the update state, so the block does not take a new key
//   while the last one is being searched; this is set by the search/update
//   pair on the cell chain.
// Reset: all entries invalid, occupancy zero, capacity 16, promote limit 1.
// Stall: a waiting result holds the update of the next key; the input side
//   drops in_ready until the output register frees.
module threshold_promote_address_list #(
  parameter int unsigned DEPTH = tpal_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input transactions
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tpal_pkg::KEY_W-1:0]        access_key,
  // result transactions
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              hit,
  output logic [tpal_pkg::POS_OUT_W-1:0]    hit_position,
  output logic [tpal_pkg::COUNT_W-1:0]      count_after,
  output logic                              promoted,
  output logic                              evicted,
  output logic [tpal_pkg::KEY_W-1:0]        evicted_key,
  output logic [tpal_pkg::OCC_OUT_W-1:0]    occupancy,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tpal_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import tpal_pkg::*;

  // position index and occupancy widths (occupancy may briefly reach DEPTH+1)
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 2);

  // config registers
  logic [CAP_W-1:0]   capacity;
  logic [LIMIT_W-1:0] promote_limit;

  // control
  tpal_state_t state, state_next;
  logic        out_free;
  logic        upd_go;

  // item and search results
  logic [KEY_W-1:0]   key_q;
  logic               hit_q;
  logic [PW-1:0]      pos_q;
  logic [COUNT_W-1:0] cnt_q;
  logic [NW-1:0]      n;
  logic [NW-1:0]      n_next;

  // cell chain
  logic [KEY_W-1:0]   cell_key   [DEPTH];
  logic [COUNT_W-1:0] cell_count [DEPTH];
  logic               cell_valid [DEPTH];
  logic [DEPTH-1:0]   cell_match;
  tpal_cell_ctrl_t    cell_ctrl  [DEPTH];

  // search-cycle logic
  logic               s_found;
  logic [PW-1:0]      s_pos;
  logic [COUNT_W-1:0] s_cnt;
  logic [COUNT_W-1:0] s_cnt_inc;

  // update-cycle logic
  logic               u_promote;
  logic [NW-1:0]      u_pos;
  logic [NW-1:0]      u_n_ins;
  logic [NW-1:0]      u_cap;
  logic               u_evict;
  logic [NW-1:0]      u_last;
  logic [NW-1:0]      u_eidx;
  logic [KEY_W-1:0]   u_ekey;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAP_RESET;
      promote_limit <= LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAPACITY:      capacity      <= cfg_data[CAP_W-1:0];
        CFG_PROMOTE_LIMIT: promote_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    upd_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        in_ready = out_free;
        upd_go   = out_free;
        if (out_free) state_next = in_valid ? ST_SEARCH : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) key_q <= access_key;
  end

  // ---------------- cell chain ----------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0]   lk;
    logic [COUNT_W-1:0] lc;
    logic               lv;
    if (g == 0) begin : g_front
      // front cell takes the accessed key with its new count
      assign lk = key_q;
      assign lc = cnt_q;
      assign lv = 1'b1;
    end else begin : g_body
      assign lk = cell_key[g-1];
      assign lc = cell_count[g-1];
      assign lv = cell_valid[g-1];
    end

    tpal_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (cell_ctrl[g]),
      .left_key   (lk),
      .left_count (lc),
      .left_valid (lv),
      .cmp_key    (key_q),
      .new_count  (cnt_q),
      .ent_key    (cell_key[g]),
      .ent_count  (cell_count[g]),
      .ent_valid  (cell_valid[g]),
      .match      (cell_match[g])
    );
  end

  // ---------------- search cycle ----------------
  // keys in the list are unique, so at most one cell matches
  always_comb begin
    s_found = 1'b0;
    s_pos   = '0;
    s_cnt   = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        s_found = 1'b1;
        s_pos   = PW'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (cell_match[i]) s_cnt = s_cnt | cell_count[i];
    end
    s_cnt_inc = (s_cnt == COUNT_MAX) ? s_cnt : s_cnt + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      hit_q <= s_found;
      pos_q <= s_pos;
      cnt_q <= s_found ? s_cnt_inc : COUNT_W'(1);
    end
  end

  // ---------------- update cycle ----------------
  always_comb begin
    u_promote = hit_q && (cnt_q > promote_limit) && (pos_q != '0);
    u_pos     = NW'(pos_q);
    u_n_ins   = hit_q ? n : n + NW'(1);
    u_cap     = (int'(capacity) > DEPTH) ? NW'(DEPTH) : NW'(capacity);
    u_evict   = u_n_ins > u_cap;
    u_last    = u_n_ins - NW'(1);
    n_next    = u_evict ? u_last : u_n_ins;

    // last entry of the rewritten list, read from the current cells
    if (u_promote && (u_pos == n - NW'(1))) u_eidx = n - NW'(2);
    else                                     u_eidx = n - NW'(1);
    u_ekey = '0;
    if (!hit_q && (n == '0)) begin
      u_ekey = key_q;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (u_eidx == NW'(i)) u_ekey = cell_key[i];
      end
    end

    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].load_left  = upd_go && (!hit_q || (u_promote && (NW'(i) <= u_pos)));
      cell_ctrl[i].load_count = upd_go && hit_q && !u_promote && (u_pos == NW'(i));
      cell_ctrl[i].clear      = upd_go && u_evict && (u_last == NW'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (upd_go) begin
      n <= n_next;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      hit          <= hit_q;
      hit_position <= hit_q ? POS_OUT_W'(pos_q) : '0;
      count_after  <= cnt_q;
      promoted     <= u_promote;
      evicted      <= u_evict;
      evicted_key  <= u_evict ? u_ekey : '0;
      occupancy    <= OCC_OUT_W'(n_next);
    end
  end

endmodule
